@@ rtl/bps_pkg.sv @@
// shared types and constants of the block parity bit scrambler
// no dependencies; used by bps_core and block_parity_bit_scrambler_top
`default_nettype none

package bps_pkg;

    // default for the largest block the datapath is sized for
    localparam int MAX_BLOCK_DEF = 64;

    // configuration port layout
    localparam int BLOCK_SIZE_W = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = BLOCK_SIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b1;

    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 7'd4;
    localparam logic                    DIR_ENCODE     = 1'b0;
    localparam logic                    DIR_DECODE     = 1'b1;

    // inversion rule chosen for a block from the previous block's counts
    typedef enum logic [1:0] {
        RULE_ALL   = 2'd0,
        RULE_ODD   = 2'd1,
        RULE_THIRD = 2'd2
    } t_rule;

endpackage

`default_nettype wire

@@ rtl/bps_core.sv @@
// per-bit scrambling state: block position, ones count and block rule
// depends on bps_pkg
`default_nettype none

module bps_core #(
    parameter int MAX_BLOCK = bps_pkg::MAX_BLOCK_DEF,
    parameter int EW        = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_data_bit,
    input  wire logic          i_start_of_message,
    input  wire logic [EW-1:0] i_size,
    input  wire logic          i_direction,
    output logic               o_out_bit
);

    localparam int PosW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CntW = $clog2(MAX_BLOCK + 1);
    localparam int PW   = ((PosW + 1) > EW) ? (PosW + 1) : EW;
    localparam int TW   = ((CntW + 1) > EW) ? (CntW + 1) : EW;

    logic [PosW-1:0]    r_pos, n_pos, c_pos;
    logic [1:0]         r_mod3, n_mod3, c_mod3;
    logic [CntW-1:0]    r_ones, n_ones, c_ones;
    bps_pkg::t_rule     r_rule, n_rule, c_rule;
    logic               flip;
    logic               dout;
    logic               block_end;
    logic [TW-1:0]      twice;
    logic [TW-1:0]      size_t;

    // state as seen by this bit, after a possible message restart
    always_comb begin
        if (i_start_of_message) begin
            c_pos  = '0;
            c_mod3 = 2'd0;
            c_ones = '0;
            c_rule = bps_pkg::RULE_ALL;
        end else begin
            c_pos  = r_pos;
            c_mod3 = r_mod3;
            c_ones = r_ones;
            c_rule = r_rule;
        end
    end

    // inversion pattern for the current position
    always_comb begin
        unique case (c_rule)
            bps_pkg::RULE_ODD:   flip = c_pos[0];
            bps_pkg::RULE_THIRD: flip = (i_size >= EW'(3)) && (c_mod3 == 2'd1);
            default:             flip = 1'b1;
        endcase
    end

    assign dout      = i_data_bit ^ flip;
    assign n_ones    = c_ones + CntW'((i_direction == bps_pkg::DIR_DECODE) ? dout : i_data_bit);
    assign block_end = (PW'(c_pos) + PW'(1)) >= PW'(i_size);
    assign twice     = TW'({n_ones, 1'b0});
    assign size_t    = TW'(i_size);

    // block close picks the next rule, otherwise advance the position
    always_comb begin
        if (block_end) begin
            n_pos  = '0;
            n_mod3 = 2'd0;
            if (twice == size_t) begin
                n_rule = bps_pkg::RULE_ALL;
            end else if (twice < size_t) begin
                n_rule = bps_pkg::RULE_ODD;
            end else begin
                n_rule = bps_pkg::RULE_THIRD;
            end
        end else begin
            n_pos  = c_pos + PosW'(1);
            n_mod3 = (c_mod3 >= 2'd2) ? 2'd0 : c_mod3 + 2'd1;
            n_rule = c_rule;
        end
    end

    // state registers, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mod3 <= 2'd0;
            r_ones <= '0;
            r_rule <= bps_pkg::RULE_ALL;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_mod3 <= n_mod3;
            r_ones <= block_end ? '0 : n_ones;
            r_rule <= n_rule;
        end
    end

    assign o_out_bit = dout;

endmodule

`default_nettype wire

@@ rtl/block_parity_bit_scrambler_top.sv @@
// Block parity bit scrambler, top level.
// Input channel i_valid/o_ready carries one message bit and a start mark per
// transfer; output channel o_valid/i_ready returns one scrambled bit for each.
// Configuration channel i_cfg_valid/o_cfg_ready writes block_size (index 0)
// or direction (index 1); it is always ready. Writes must be made while idle,
// which the block does not enforce. A bit accepted into the input register
// passes through the scramble logic into the output register, which shows it.
// Throughput: one bit per cycle while the output is not stalled; the running
// block state closes its loop through the core's state registers.
// A stalled receiver holds the output register; one more bit can wait in the
// input register, after which o_ready drops until the output drains.
// Reset clears both registers' valid flags, sets block size 4, encode mode,
// and starts a fresh message with every bit of the first block inverted.
// Depends on bps_pkg and bps_core.
`default_nettype none

module block_parity_bit_scrambler_top #(
    parameter int MAX_BLOCK = bps_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input bits
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_data_bit,
    input  wire logic                           i_start_of_message,
    // output bits
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_out_bit
);

    localparam int CntW = $clog2(MAX_BLOCK + 1);
    localparam int EW   = (CntW > bps_pkg::BLOCK_SIZE_W) ? CntW : bps_pkg::BLOCK_SIZE_W;

    logic [bps_pkg::BLOCK_SIZE_W-1:0] r_block_size;
    logic                             r_direction;
    logic                             r_in_valid;
    logic                             r_in_bit;
    logic                             r_in_som;
    logic                             r_out_valid;
    logic                             r_out_bit;
    logic [EW-1:0]                    size_ext;
    logic [EW-1:0]                    size_eff;
    logic                             advance;
    logic                             core_bit;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= bps_pkg::BLOCK_SIZE_RST;
            r_direction  <= bps_pkg::DIR_ENCODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bps_pkg::CFG_BLOCK_SIZE: r_block_size <= i_cfg_data;
                bps_pkg::CFG_DIRECTION:  r_direction  <= i_cfg_data[0];
                default:                 r_direction  <= r_direction;
            endcase
        end
    end

    // effective block size: zero acts as one, saturate at the maximum
    assign size_ext = EW'(r_block_size);
    always_comb begin
        if (size_ext == '0) begin
            size_eff = EW'(1);
        end else if (size_ext > EW'(MAX_BLOCK)) begin
            size_eff = EW'(MAX_BLOCK);
        end else begin
            size_eff = size_ext;
        end
    end

    // handshake: stage moves when the output register is free or draining
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_bit <= i_data_bit;
            r_in_som <= i_start_of_message;
        end
    end

    // scrambling state and per-bit logic
    bps_core #(
        .MAX_BLOCK (MAX_BLOCK),
        .EW        (EW)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (advance),
        .i_data_bit         (r_in_bit),
        .i_start_of_message (r_in_som),
        .i_size             (size_eff),
        .i_direction        (r_direction),
        .o_out_bit          (core_bit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bit <= core_bit;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_bit = r_out_bit;

endmodule

`default_nettype wire
